// File: rtl/core/kl_pkg.sv
// Package for the keyword lexer: the state enums, the token codes, the keyword table
// and the character classes.
// It has no dependencies. Every other file imports it.
package kl_pkg;

   localparam int CHAR_W     = 8;
   localparam int KIND_W     = 3;
   localparam int KW_ID_W    = 4;
   localparam int VALUE_W    = 32;
   localparam int DIGIT_W    = 4;
   localparam int KW_COUNT   = 10;
   localparam int KW_MAX_LEN = 8;
   localparam int KW_POS_W   = $clog2(KW_MAX_LEN);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_NAME,
      MODE_NUM
   } kl_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHAR,
      ST_MUL,
      ST_ADD,
      ST_NAME_RD,
      ST_NAME_OUT,
      ST_NUM_OUT,
      ST_ONE_OUT
   } kl_state_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_IDENT    = 3'd0,
      KIND_KEYWORD  = 3'd1,
      KIND_NUMBER   = 3'd2,
      KIND_OPERATOR = 3'd3,
      KIND_PUNCT    = 3'd4
   } kl_kind_type;

   typedef enum logic {
      ALU_TIMES5,
      ALU_DOUBLE_ADD
   } kl_alu_op_type;

   // Keyword spelling, left aligned, first character in the top byte.
   function automatic logic [KW_MAX_LEN*CHAR_W-1:0] kw_word(input logic [KW_ID_W-1:0] k);
      logic [KW_MAX_LEN*CHAR_W-1:0] w;
      unique case (k)
         4'd0:    w = {"IF", 48'd0};
         4'd1:    w = {"ELSE", 32'd0};
         4'd2:    w = {"ENDIF", 24'd0};
         4'd3:    w = {"END", 40'd0};
         4'd4:    w = {"BEGIN", 24'd0};
         4'd5:    w = {"VAR", 40'd0};
         4'd6:    w = {"WHILE", 24'd0};
         4'd7:    w = "ENDWHILE";
         4'd8:    w = {"READ", 32'd0};
         4'd9:    w = {"WRITE", 24'd0};
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [KW_ID_W-1:0] kw_len(input logic [KW_ID_W-1:0] k);
      logic [KW_ID_W-1:0] n;
      unique case (k)
         4'd0:    n = 4'd2;
         4'd1:    n = 4'd4;
         4'd2:    n = 4'd5;
         4'd3:    n = 4'd3;
         4'd4:    n = 4'd5;
         4'd5:    n = 4'd3;
         4'd6:    n = 4'd5;
         4'd7:    n = 4'd8;
         4'd8:    n = 4'd4;
         4'd9:    n = 4'd5;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [CHAR_W-1:0] kw_char(input logic [KW_ID_W-1:0] k,
                                                 input logic [KW_POS_W-1:0] p);
      logic [KW_MAX_LEN*CHAR_W-1:0] w;
      w = kw_word(k);
      return w[(KW_MAX_LEN - 1 - int'(p)) * CHAR_W +: CHAR_W];
   endfunction

   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
   endfunction

   function automatic logic is_operator(input logic [CHAR_W-1:0] c);
      return c == "+" || c == "-" || c == "/" || c == "*" ||
             c == "<" || c == ">" || c == ":" || c == "=";
   endfunction

   function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

endpackage

// File: rtl/core/kl_channels.sv
// Valid/ready channel interfaces for the keyword lexer: requests in, tokens out.
// They depend on kl_pkg for the field widths.
interface kl_req_if import kl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   logic              end_of_input;

   modport source (output valid, output char_in, output end_of_input, input ready);
   modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface kl_rsp_if import kl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  token_kind;
   logic [KW_ID_W-1:0] keyword_id;
   logic [CHAR_W-1:0]  text_char;
   logic [VALUE_W-1:0] number_value;
   logic               last;

   modport source (output valid, output token_kind, output keyword_id, output text_char,
                   output number_value, output last, input ready);
   modport sink   (input valid, input token_kind, input keyword_id, input text_char,
                   input number_value, input last, output ready);
endinterface

// File: rtl/core/keyword_lexer.sv
// Top level of the keyword lexer: the sequencer, the token registers and the output register.
// It depends on kl_pkg, kl_channels, kl_alu, kl_name_mem and kl_kw_match.
//
//   channel   dir  handshake          payload
//   req_ch    in   valid / ready      char_in[7:0], end_of_input
//   rsp_ch    out  valid / ready      token_kind[2:0], keyword_id[3:0], text_char[7:0],
//                                     number_value[31:0], last
//
// Every request is accepted in ST_IDLE and classified in ST_CHAR. A digit that extends a
// number also passes ST_MUL and ST_ADD, because the shared shift-add unit first forms acc*5
// and then acc*2+digit. Emitting a name passes ST_NAME_RD and ST_NAME_OUT for each character,
// since each character is read through the registered port of the name buffer. A number or a
// single-character token is emitted from ST_NUM_OUT or ST_ONE_OUT, held there while the output
// stalls. A character that ends a pending token is classified once more after that token is out.
// Reset is synchronous and brings the block to idle with no token pending. The name buffer
// is not cleared, because only entries that were already written are ever read back.
// Backpressure on rsp_ch holds the sequencer in its emit state. The output register frees
// the emit state as soon as the register is loaded.
module keyword_lexer import kl_pkg::*; #(
   parameter int NAME_LIMIT  = 16,
   parameter int NUMBER_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   kl_req_if.sink   req_ch,
   kl_rsp_if.source rsp_ch
);
   localparam int BUF_DEPTH = NAME_LIMIT - 1;
   localparam int ADDR_W    = $clog2(BUF_DEPTH);
   localparam int LEN_W     = $clog2(NAME_LIMIT);

   kl_state_type           state_ff, state_in;
   kl_mode_type            mode_ff, mode_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [LEN_W-1:0]       idx_ff, idx_in;
   logic [NUMBER_BITS-1:0] acc_ff, acc_in;
   logic [CHAR_W-1:0]      char_ff, char_in;
   logic                   eoi_ff, eoi_in;
   logic                   pend_ff, pend_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [KW_ID_W-1:0]     rsp_kid_ff, rsp_kid_in;
   logic [CHAR_W-1:0]      rsp_text_ff, rsp_text_in;
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                   rsp_last_ff, rsp_last_in;

   // The current character is classified in ST_CHAR after the request is accepted, and again after a flush.
   logic                   c_letter, c_digit, c_space, c_oper;
   logic [CHAR_W-1:0]      c_upper;
   logic                   cont_name, start_name, add_char, at_limit;
   logic                   cont_num, start_num, one_tok, flush;
   logic [LEN_W-1:0]       len_inc;

   logic                   accept;
   logic                   emit_name, emit_num, emit_one, emit, load;
   logic                   last_char, done_tok;
   logic                   mem_we;
   kl_alu_op_type          alu_op;
   logic [NUMBER_BITS-1:0] alu_result;
   logic [CHAR_W-1:0]      buf_data;
   logic [KW_ID_W-1:0]     kw_id;

   assign c_letter = is_letter(char_ff);
   assign c_digit  = is_digit(char_ff);
   assign c_space  = is_space(char_ff);
   assign c_oper   = is_operator(char_ff);
   assign c_upper  = to_upper(char_ff);
   assign len_inc  = len_ff + LEN_W'(1);

   assign cont_name  = mode_ff == MODE_NAME && (c_letter || c_digit) && !eoi_ff;
   assign start_name = mode_ff == MODE_IDLE && c_letter && !eoi_ff;
   assign add_char   = cont_name || start_name;
   assign at_limit   = len_inc == LEN_W'(BUF_DEPTH);
   assign cont_num   = mode_ff == MODE_NUM && c_digit && !eoi_ff;
   assign start_num  = mode_ff == MODE_IDLE && c_digit && !eoi_ff;
   assign one_tok    = mode_ff == MODE_IDLE && !eoi_ff && !c_letter && !c_digit && !c_space;
   // Any character that does not extend the pending token ends it. So does end of input.
   assign flush      = mode_ff != MODE_IDLE && !cont_name && !cont_num;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_CHAR;
         end
         ST_CHAR: begin
            if (flush) begin
               state_in = (mode_ff == MODE_NAME) ? ST_NAME_RD : ST_NUM_OUT;
            end else if (add_char && at_limit) begin
               state_in = ST_NAME_RD;
            end else if (cont_num) begin
               state_in = ST_MUL;
            end else if (one_tok) begin
               state_in = ST_ONE_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: state_in = ST_ADD;
         ST_ADD: state_in = ST_IDLE;
         ST_NAME_RD: state_in = ST_NAME_OUT;
         ST_NAME_OUT: begin
            if (load) begin
               if (!last_char) state_in = ST_NAME_RD;
               else            state_in = pend_ff ? ST_CHAR : ST_IDLE;
            end
         end
         ST_NUM_OUT: begin
            if (load) state_in = pend_ff ? ST_CHAR : ST_IDLE;
         end
         ST_ONE_OUT: begin
            if (load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_ch.ready = state_ff == ST_IDLE;
      emit_name    = state_ff == ST_NAME_OUT;
      emit_num     = state_ff == ST_NUM_OUT;
      emit_one     = state_ff == ST_ONE_OUT;
      mem_we       = state_ff == ST_CHAR && add_char;
      alu_op       = (state_ff == ST_MUL) ? ALU_TIMES5 : ALU_DOUBLE_ADD;
   end

   assign accept    = req_ch.valid && req_ch.ready;
   assign emit      = emit_name || emit_num || emit_one;
   assign load      = emit && (!rsp_valid_ff || rsp_ch.ready);
   assign last_char = idx_ff == len_ff - LEN_W'(1);
   assign done_tok  = load && (emit_num || emit_one || (emit_name && last_char));

   kl_alu #(
      .DATA_W (NUMBER_BITS)
   ) u_alu (
      .op     (alu_op),
      .acc    (acc_ff),
      .digit  (char_ff[DIGIT_W-1:0]),
      .result (alu_result)
   );

   kl_name_mem #(
      .DEPTH   (BUF_DEPTH)
   ) u_name_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (c_upper),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (buf_data)
   );

   kl_kw_match #(
      .LEN_W   (LEN_W)
   ) u_kw_match (
      .clock   (clock),
      .step_en (mem_we),
      .pos     (len_ff),
      .ch      (c_upper),
      .kw_id   (kw_id)
   );

   // Token registers.
   always_comb begin
      char_in = char_ff;
      eoi_in  = eoi_ff;
      mode_in = mode_ff;
      len_in  = len_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      pend_in = pend_ff;

      if (accept) begin
         char_in = req_ch.char_in;
         eoi_in  = req_ch.end_of_input;
      end

      if (state_ff == ST_CHAR) begin
         // The character is kept for a second pass once the flushed token is out.
         pend_in = flush && !eoi_ff;
         idx_in  = '0;
         if (start_name) mode_in = MODE_NAME;
         if (add_char)   len_in = len_inc;
         if (start_num) begin
            mode_in = MODE_NUM;
            acc_in  = {{(NUMBER_BITS-DIGIT_W){1'b0}}, char_ff[DIGIT_W-1:0]};
         end
      end

      if (state_ff == ST_MUL || state_ff == ST_ADD) acc_in = alu_result;

      if (emit_name && load) idx_in = idx_ff + LEN_W'(1);

      if (done_tok) begin
         mode_in = MODE_IDLE;
         len_in  = '0;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_kid_in   = rsp_kid_ff;
      rsp_text_in  = rsp_text_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_kid_in   = '0;
         rsp_text_in  = '0;
         rsp_value_in = '0;
         rsp_last_in  = 1'b1;
         if (emit_name) begin
            rsp_kind_in = (kw_id != '0) ? KIND_KEYWORD : KIND_IDENT;
            rsp_kid_in  = kw_id;
            rsp_text_in = buf_data;
            rsp_last_in = last_char;
         end else if (emit_num) begin
            rsp_kind_in  = KIND_NUMBER;
            rsp_value_in = VALUE_W'(acc_ff);
         end else begin
            rsp_kind_in = c_oper ? KIND_OPERATOR : KIND_PUNCT;
            rsp_text_in = char_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_IDLE;
         len_ff       <= '0;
         acc_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         len_ff       <= len_in;
         acc_ff       <= acc_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      eoi_ff       <= eoi_in;
      idx_ff       <= idx_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_kid_ff   <= rsp_kid_in;
      rsp_text_ff  <= rsp_text_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.token_kind   = rsp_kind_ff;
   assign rsp_ch.keyword_id   = rsp_kid_ff;
   assign rsp_ch.text_char    = rsp_text_ff;
   assign rsp_ch.number_value = rsp_value_ff;
   assign rsp_ch.last         = rsp_last_ff;
endmodule

// File: rtl/core/kl_alu.sv
// The shared shift-add unit of the keyword lexer. It forms value*10+digit in two passes.
// It depends on kl_pkg.
module kl_alu import kl_pkg::*; #(
   parameter int DATA_W = 32
) (
   input  kl_alu_op_type      op,
   input  logic [DATA_W-1:0]  acc,
   input  logic [DIGIT_W-1:0] digit,
   output logic [DATA_W-1:0]  result
);
   logic [DATA_W-1:0] opa;
   logic [DATA_W-1:0] opb;

   always_comb begin
      unique case (op)
         ALU_TIMES5: begin
            opa = acc << 2;
            opb = acc;
         end
         ALU_DOUBLE_ADD: begin
            opa = acc << 1;
            opb = {{(DATA_W-DIGIT_W){1'b0}}, digit};
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign result = opa + opb;
endmodule

// File: rtl/core/kl_name_mem.sv
// Name buffer of the keyword lexer: one write port and one registered read port.
// It depends on kl_pkg for the character width.
module kl_name_mem import kl_pkg::*; #(
   parameter int DEPTH = 15
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [CHAR_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [CHAR_W-1:0]        rd_data
);
   logic [CHAR_W-1:0] mem_ff [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/kl_kw_match.sv
// Keyword matcher of the keyword lexer. It keeps a flag for each keyword that the name so
// far is still a prefix of, and it gives the matching keyword's id. It depends on kl_pkg.
module kl_kw_match import kl_pkg::*; #(
   parameter int LEN_W = 4
) (
   input  logic               clock,
   input  logic               step_en,
   input  logic [LEN_W-1:0]   pos,
   input  logic [CHAR_W-1:0]  ch,
   output logic [KW_ID_W-1:0] kw_id
);
   logic [KW_COUNT-1:0] alive_ff;
   logic [KW_COUNT-1:0] alive_in;
   logic [KW_COUNT-1:0] base;
   logic                in_range;

   // A new name starts at position zero with every keyword still possible.
   always_comb begin
      base     = (pos == '0) ? '1 : alive_ff;
      in_range = pos < LEN_W'(KW_MAX_LEN);
      for (int k = 0; k < KW_COUNT; k++) begin
         alive_in[k] = base[k] && in_range && (pos < LEN_W'(kw_len(KW_ID_W'(k)))) &&
                       (kw_char(KW_ID_W'(k), pos[KW_POS_W-1:0]) == ch);
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         alive_ff <= alive_in;
      end
   end

   // Once the name is complete, pos holds its length. A keyword matches when it is still
   // a prefix and has exactly that length.
   always_comb begin
      kw_id = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (alive_ff[k] && pos == LEN_W'(kw_len(KW_ID_W'(k)))) begin
            kw_id = KW_ID_W'(k + 1);
         end
      end
   end
endmodule
